// ===== sv/rtfb_pkg.sv =====
// Package: types, command constants and word selection for the frame builder.
`timescale 1ns / 1ps
package rtfb_pkg;

  // Radio command words
  localparam logic [15:0] CMD_TX_ON    = 16'h8238;
  localparam logic [15:0] CMD_PREAMBLE = 16'hB8AA;
  localparam logic [15:0] CMD_SYNC_HI  = 16'hB82D;
  localparam logic [15:0] CMD_SYNC_LO  = 16'hB8D4;
  localparam logic [15:0] CMD_FIFO_WR  = 16'hB800;
  localparam logic [15:0] CMD_TX_OFF   = 16'h8208;

  // Sequencer steps: header, payload byte, checksum, trailer
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_TX_ON   = 4'd0;
  localparam step_t STEP_PRE_0   = 4'd1;
  localparam step_t STEP_PRE_1   = 4'd2;
  localparam step_t STEP_PRE_2   = 4'd3;
  localparam step_t STEP_SYNC_HI = 4'd4;
  localparam step_t STEP_SYNC_LO = 4'd5;
  localparam step_t STEP_DATA    = 4'd6;
  localparam step_t STEP_SUM     = 4'd7;
  localparam step_t STEP_DUM_0   = 4'd8;
  localparam step_t STEP_DUM_1   = 4'd9;
  localparam step_t STEP_DUM_2   = 4'd10;
  localparam step_t STEP_TX_OFF  = 4'd11;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Classified request handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic [7:0] checksum;
  } desc_t;

  // Command word for one step of a request
  function automatic logic [15:0] word_for_step(step_t step, logic [7:0] data_byte,
                                                logic [7:0] checksum);
    logic [15:0] w;
    case (step)
      STEP_TX_ON:   w = CMD_TX_ON;
      STEP_PRE_0:   w = CMD_PREAMBLE;
      STEP_PRE_1:   w = CMD_PREAMBLE;
      STEP_PRE_2:   w = CMD_PREAMBLE;
      STEP_SYNC_HI: w = CMD_SYNC_HI;
      STEP_SYNC_LO: w = CMD_SYNC_LO;
      STEP_DATA:    w = CMD_FIFO_WR | {8'h00, data_byte};
      STEP_SUM:     w = CMD_FIFO_WR | {8'h00, checksum};
      STEP_DUM_0:   w = CMD_PREAMBLE;
      STEP_DUM_1:   w = CMD_PREAMBLE;
      STEP_DUM_2:   w = CMD_PREAMBLE;
      STEP_TX_OFF:  w = CMD_TX_OFF;
      default:      w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/rtfb_in_if.sv =====
// Interface: payload byte channel with valid/ready handshake.
`timescale 1ns / 1ps
interface rtfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/rtfb_out_if.sv =====
// Interface: command word channel with valid/ready handshake.
`timescale 1ns / 1ps
interface rtfb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] command_word;
  logic        end_of_run;

  modport source(output valid, output command_word, output end_of_run, input ready);
  modport sink(input valid, input command_word, input end_of_run, output ready);
endinterface

// ===== sv/rtfb_front.sv =====
// Front end: accepts payload bytes, tracks frame state and the running checksum.
`timescale 1ns / 1ps
module rtfb_front (
  input  logic            clk,
  input  logic            rst,
  rtfb_in_if.sink         bytes,
  input  logic            q_full,
  output logic            push,
  output rtfb_pkg::desc_t push_desc
);
  import rtfb_pkg::*;

  logic       in_frame;
  logic [7:0] running_sum;
  logic [7:0] sum_next;

  // Take a request whenever the queue has room
  always_comb begin
    bytes.ready          = ~q_full;
    push                 = bytes.valid & ~q_full;
    sum_next             = (in_frame ? running_sum : 8'h00) + bytes.data_byte;
    push_desc.data_byte  = bytes.data_byte;
    push_desc.first      = ~in_frame;
    push_desc.last       = bytes.last_byte;
    push_desc.checksum   = sum_next;
  end

  // Open, advance and close the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      running_sum <= 8'h00;
    end else if (push) begin
      if (bytes.last_byte) begin
        in_frame    <= 1'b0;
        running_sum <= 8'h00;
      end else begin
        in_frame    <= 1'b1;
        running_sum <= sum_next;
      end
    end
  end

endmodule

// ===== sv/rtfb_queue.sv =====
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps
module rtfb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtfb_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rtfb_pkg::desc_t head
);
  import rtfb_pkg::*;

  desc_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    full       = (count == QCNT_W'(QDEPTH));
    head_valid = (count != '0);
    head       = slots[rd_ptr];
    do_push    = push & ~full;
    do_pop     = pop & head_valid;
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/rtfb_back.sv =====
// Back end: steps through the command words of each request into an output register.
`timescale 1ns / 1ps
module rtfb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  rtfb_pkg::desc_t head,
  output logic            pop,
  rtfb_out_if.source      words
);
  import rtfb_pkg::*;

  logic        active;
  step_t       step;
  step_t       step_cur;
  step_t       step_end;
  logic        load;
  logic        fire;
  logic        out_valid;
  logic [15:0] out_word;
  logic        out_eor;

  // Pick the current step and whether this word finishes the request
  always_comb begin
    load     = ~out_valid | words.ready;
    step_cur = active ? step : (head.first ? STEP_TX_ON : STEP_DATA);
    step_end = head.last ? STEP_TX_OFF : STEP_DATA;
    fire     = head_valid & load;
    pop      = fire & (step_cur == step_end);
    words.valid        = out_valid;
    words.command_word = out_word;
    words.end_of_run   = out_eor;
  end

  // Advance the sequencer and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      step      <= STEP_TX_ON;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= head_valid;
      if (fire) begin
        if (pop) begin
          active <= 1'b0;
        end else begin
          active <= 1'b1;
          step   <= step_cur + 1'b1;
        end
      end
    end
  end

  // Hold the word until it is taken
  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= word_for_step(step_cur, head.data_byte, head.checksum);
      out_eor  <= pop;
    end
  end

endmodule

// ===== sv/radio_tx_frame_builder.sv =====
// Top level: frame builder turning payload bytes into radio command words.
// A request waits in a queue slot; its words leave through the back-end output register.
// The back-end sequencer gives one word per cycle while words are taken; a mid-frame
// byte gives 1 word, a frame's first byte 7, its last byte 6, a lone byte 12.
// A four-entry request queue lets bytes be accepted while header and trailer run.
// Reset (synchronous, active high) closes any frame, clears the sum and empties the queue.
`timescale 1ns / 1ps
module radio_tx_frame_builder (
  input  logic        clk,
  input  logic        rst,
  rtfb_in_if.sink     bytes,
  rtfb_out_if.source  words
);
  import rtfb_pkg::*;

  logic  push;
  desc_t push_desc;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  desc_t head;

  rtfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  rtfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rtfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .words      (words)
  );

endmodule
